// ===== hw/rtl/vars_pkg.sv =====
// Shared types and constants for the attack/release smoother.
// No dependencies; imported by vactrol_attack_release_smoother_core.
`default_nettype none

package vars_pkg;

	// Sequencer states: two shift-add multiplies, then a restoring divide.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULK,
		ST_FAC,
		ST_MULT,
		ST_DEN,
		ST_DIV,
		ST_FIN
	} state_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_RATE_BASE = 2'd0,
		REG_RISE_TIME = 2'd1,
		REG_FALL_TIME = 2'd2
	} reg_idx_t;

	localparam int CFG_W  = 24;
	localparam int SMP_W  = 16;
	localparam int ST_W   = 18;
	localparam int CNT_W  = 5;

	localparam logic [CFG_W-1:0] RATE_BASE_RST = 24'd1098066;
	localparam logic [CFG_W-1:0] RISE_TIME_RST = 24'd5120;
	localparam logic [CFG_W-1:0] FALL_TIME_RST = 24'd768000;

	// State coefficients 0.999 and 0.9 in unsigned Q0.16.
	localparam logic [15:0] K_RISE = 16'd65470;
	localparam logic [15:0] K_FALL = 16'd58982;

	// Time offsets 1.0 and 10.0 in Q.8.
	localparam logic [26:0] RISE_OFFSET = 27'd256;
	localparam logic [26:0] FALL_OFFSET = 27'd2560;

	// One in Q.31 for the time factor.
	localparam logic [33:0] ONE_Q31 = 34'h0_8000_0000;

	localparam logic [CNT_W-1:0] MULK_STEPS = 5'd16;
	localparam logic [CNT_W-1:0] MULT_STEPS = 5'd24;
	localparam logic [CNT_W-1:0] DIV_STEPS  = 5'd18;

endpackage

`default_nettype wire

// ===== hw/rtl/vactrol_attack_release_smoother_core.sv =====
// Attack/release smoother: state-dependent trapezoidal one-pole lowpass.
// Depends on vars_pkg for the sequencer states, register indexes and constants.
//
//   channel  signals                                   dir   beat
//   in       in_valid, in_ready, sample_in[15:0]       in    one Q1.15 sample
//   out      out_valid, out_ready, sample_out[15:0]    out   one Q1.15 sample
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data in    one 24-bit register write
//
// A new input beat is accepted only in idle, so a sample is not taken until the last one
// is written back. Each sample passes through acceptance, the state-coefficient multiply,
// the time factor, the time-scale multiply (the numerator multiply runs alongside),
// divisor setup, the bit-serial divide and writeback, in that order.
// A full output register stalls the writeback until out_ready.
// Reset clears the filter state and loads the register defaults; cfg_ready is always high.
`default_nettype none

module vactrol_attack_release_smoother_core
	import vars_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [15:0]      sample_in,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [15:0]           sample_out,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q;
	logic [CFG_W-1:0] rate_base_q, rise_time_q, fall_time_q;
	logic [ST_W-1:0]  s_q;
	logic             out_valid_q;
	logic [15:0]      out_data_q;

	logic        rise_q;
	logic [17:0] mag_q;
	logic [33:0] mc_q;
	logic [33:0] acc_h_q;
	logic [23:0] acc_l_q;
	logic [17:0] num_h_q;
	logic [23:0] num_l_q;
	logic [43:0] den_q;
	logic [43:0] rem_q;
	logic [17:0] quo_q;

	logic        out_free, fin_load, step_done;
	logic [18:0] d_val, d_abs;
	logic [17:0] s_abs;
	logic [34:0] mul_sum;
	logic [18:0] num_sum;
	logic [33:0] p1, fac;
	logic [26:0] t_val;
	logic [43:0] den_val, n_val;
	logic [44:0] trial;
	logic [45:0] diff;
	logic        fits;
	logic [19:0] x_val;
	logic [20:0] y_val, ns_val;
	logic [15:0] y_sat;
	logic [17:0] ns_sat;

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign sample_out = out_data_q;
	assign out_free   = !out_valid_q || out_ready;
	assign step_done  = (cnt_q == '0);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		fin_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_MULK;
			end
			ST_MULK: if (step_done) state_d = ST_FAC;
			ST_FAC:  state_d = ST_MULT;
			ST_MULT: if (step_done) state_d = ST_DEN;
			ST_DEN:  state_d = ST_DIV;
			ST_DIV:  if (step_done) state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					fin_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		// difference and magnitudes at acceptance
		d_val = {{3{sample_in[15]}}, sample_in} - {s_q[17], s_q};
		d_abs = d_val[18] ? (19'd0 - d_val) : d_val;
		s_abs = s_q[17] ? (18'd0 - s_q) : s_q;

		// shared shift-add step: add multiplicand at top, shift right
		mul_sum = {1'b0, acc_h_q} + (acc_l_q[0] ? {1'b0, mc_q} : 35'd0);
		num_sum = {1'b0, num_h_q} + (num_l_q[0] ? {1'b0, mag_q} : 19'd0);

		// time factor 1 - k*s, clamped at zero
		p1 = {acc_h_q[17:0], acc_l_q[23:8]};
		if (s_q[17])
			fac = ONE_Q31 + p1;
		else if (p1 > ONE_Q31)
			fac = '0;
		else
			fac = ONE_Q31 - p1;

		t_val   = acc_h_q[33:7] + (rise_q ? RISE_OFFSET : FALL_OFFSET);
		den_val = {1'b0, t_val, 16'd0} + {20'd0, rate_base_q};
		n_val   = {2'b00, num_h_q, num_l_q} + {1'b0, den_val[43:1]};

		// restoring divide step
		trial = {rem_q, quo_q[17]};
		diff  = {1'b0, trial} - {2'b00, den_q};
		fits  = !diff[45];

		// writeback
		x_val  = rise_q ? {2'b00, quo_q} : (20'd0 - {2'b00, quo_q});
		y_val  = {{3{s_q[17]}}, s_q} + {x_val[19], x_val};
		ns_val = y_val + {x_val[19], x_val};
		if ($signed(y_val) > 21'sd32767)
			y_sat = 16'h7fff;
		else if ($signed(y_val) < -21'sd32768)
			y_sat = 16'h8000;
		else
			y_sat = y_val[15:0];
		if ($signed(ns_val) > 21'sd131071)
			ns_sat = 18'h1ffff;
		else if ($signed(ns_val) < -21'sd131072)
			ns_sat = 18'h20000;
		else
			ns_sat = ns_val[17:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			s_q         <= '0;
			out_valid_q <= 1'b0;
			rate_base_q <= RATE_BASE_RST;
			rise_time_q <= RISE_TIME_RST;
			fall_time_q <= FALL_TIME_RST;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: cnt_q <= MULK_STEPS - 5'd1;
				ST_FAC:  cnt_q <= MULT_STEPS - 5'd1;
				ST_DEN:  cnt_q <= DIV_STEPS - 5'd1;
				default: if (!step_done) cnt_q <= cnt_q - 5'd1;
			endcase
			if (fin_load) begin
				s_q         <= ns_sat;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_RATE_BASE: rate_base_q <= cfg_data;
					REG_RISE_TIME: rise_time_q <= cfg_data;
					REG_FALL_TIME: fall_time_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					rise_q  <= !d_val[18];
					mag_q   <= d_abs[17:0];
					mc_q    <= {16'd0, s_abs};
					acc_h_q <= '0;
					acc_l_q <= {8'd0, d_val[18] ? K_FALL : K_RISE};
				end
			end
			ST_MULK: begin
				acc_h_q <= mul_sum[34:1];
				acc_l_q <= {mul_sum[0], acc_l_q[23:1]};
			end
			ST_FAC: begin
				mc_q    <= fac;
				acc_h_q <= '0;
				acc_l_q <= rise_q ? rise_time_q : fall_time_q;
				num_h_q <= '0;
				num_l_q <= rate_base_q;
			end
			ST_MULT: begin
				acc_h_q <= mul_sum[34:1];
				acc_l_q <= {mul_sum[0], acc_l_q[23:1]};
				num_h_q <= num_sum[18:1];
				num_l_q <= {num_sum[0], num_l_q[23:1]};
			end
			ST_DEN: begin
				den_q <= den_val;
				// seed the divider once the divisor is known
				rem_q <= {18'd0, n_val[43:18]};
				quo_q <= n_val[17:0];
			end
			ST_DIV: begin
				rem_q <= fits ? diff[43:0] : trial[43:0];
				quo_q <= {quo_q[16:0], fits};
			end
			ST_FIN: begin
				if (out_free) out_data_q <= y_sat;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire
